### hw/rtl/crs_pkg.sv
// ============================================================================
// Catmull-Rom curve sampler package
// Shared constants, register indexes and interface structs of the sampler.
// ============================================================================
package crs_pkg;

    // Default coordinate width and depth of the segment queue.
    localparam int CRS_COORD_WIDTH = 24;
    localparam int CRS_QUEUE_DEPTH = 2;

    // Configuration port.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_T_STEP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = CFG_IDX_W'(1);

    localparam logic [15:0] T_STEP_RESET = 16'd16384;
    localparam logic [15:0] GAIN_RESET   = 16'd8192;
    // Smallest step honored; smaller values are raised to it.
    localparam logic [15:0] STEP_MIN     = 16'd2048;

    typedef struct packed {
        logic [15:0] t_step;
        logic [15:0] gain;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### hw/rtl/crs_queue.sv
// ============================================================================
// Segment queue
// Small register FIFO that decouples the point front end from the sampler.
// ============================================================================
module crs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = crs_pkg::CRS_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_push_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_pop_data,
    output crs_pkg::t_q_status   o_status
);
    import crs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    n_wr_ptr;
    logic [AW-1:0]    n_rd_ptr;
    logic [CW-1:0]    n_count;

    always_comb begin
        n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_pop_data      = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == CW'(DEPTH));
    assign o_status.empty  = (r_count == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("segment queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("segment queue read while empty");

endmodule

### hw/rtl/crs_front.sv
// ============================================================================
// Point front end
// Keeps the four-point window, doubles curve end points and queues segments.
// ============================================================================
module crs_front #(
    parameter int W = crs_pkg::CRS_COORD_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic signed [W-1:0]    i_px,
    input  logic signed [W-1:0]    i_py,
    input  logic signed [W-1:0]    i_pz,
    input  logic                   i_final_point,
    output logic                   o_push,
    output logic [12*W:0]          o_push_data,
    input  crs_pkg::t_q_status     i_q_status
);
    import crs_pkg::*;

    typedef logic [2:0][W-1:0]      t_pt;
    typedef logic [3:0][2:0][W-1:0] t_win;

    // Enters one point; index 0 of the window holds the oldest point.
    function automatic t_win push_pt(t_win w, logic [2:0] f, t_pt p);
        t_win r;
        r = w;
        if (f < 3'd4) begin
            r[f[1:0]] = p;
        end else begin
            r[2:0] = w[3:1];
            r[3]   = p;
        end
        return r;
    endfunction

    function automatic logic [2:0] fill_inc(logic [2:0] f);
        return (f < 3'd4) ? f + 3'd1 : f;
    endfunction

    t_win        r_win;
    logic [2:0]  r_fill;
    logic        r_pend_v;
    logic [12*W:0] r_pend;

    t_pt         w_pt;
    t_win        w_win_a;
    t_win        w_win_b;
    t_win        w_win_c;
    logic [2:0]  w_fill_a;
    logic [2:0]  w_fill_b;
    logic [2:0]  w_fill_c;
    logic        w_job1;
    logic        w_job2;
    logic        w_accept;

    assign w_pt[0] = i_px;
    assign w_pt[1] = i_py;
    assign w_pt[2] = i_pz;

    always_comb begin
        // The first point of a curve goes in twice.
        w_win_a  = r_win;
        w_fill_a = r_fill;
        if (r_fill == 3'd0) begin
            w_win_a  = push_pt(r_win, r_fill, w_pt);
            w_fill_a = 3'd1;
        end
        w_win_b  = push_pt(w_win_a, w_fill_a, w_pt);
        w_fill_b = fill_inc(w_fill_a);
        // A final point goes in a second time to close the curve.
        w_win_c  = push_pt(w_win_b, w_fill_b, w_pt);
        w_fill_c = fill_inc(w_fill_b);
        w_job1   = (w_fill_b == 3'd4);
        w_job2   = i_final_point && (w_fill_c == 3'd4);
    end

    assign o_in_stall = r_pend_v || i_q_status.full;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        o_push      = (w_accept && (w_job1 || w_job2)) || (r_pend_v && !i_q_status.full);
        o_push_data = w_job1 ? {!w_job2, w_win_b} : {1'b1, w_win_c};
        if (r_pend_v) begin
            o_push_data = r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= '0;
            r_fill   <= 3'd0;
            r_pend_v <= 1'b0;
        end else begin
            if (w_accept) begin
                if (i_final_point) begin
                    r_win  <= '0;
                    r_fill <= 3'd0;
                end else begin
                    r_win  <= w_win_b;
                    r_fill <= w_fill_b;
                end
                if (w_job1 && w_job2) begin
                    r_pend_v <= 1'b1;
                end
            end else if (r_pend_v && !i_q_status.full) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend <= {1'b1, w_win_c};
        end
    end

    a_pend_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_fill == 3'd0))
        else $error("held closing segment while window is not empty");

    a_fill_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != 3'd1) && (r_fill <= 3'd4))
        else $error("window fill count out of its legal set");

endmodule

### hw/rtl/crs_lane.sv
// ============================================================================
// Coordinate lane
// Evaluates the cubic for one coordinate, scales by gain and saturates.
// ============================================================================
module crs_lane #(
    parameter int W = crs_pkg::CRS_COORD_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [15:0]           i_gain,
    input  logic [15:0]           i_t,
    input  logic [15:0]           i_t2,
    input  logic [15:0]           i_t3,
    input  logic signed [W+3:0]   i_c0,
    input  logic signed [W+3:0]   i_c1,
    input  logic signed [W+3:0]   i_c2,
    input  logic signed [W+3:0]   i_c3,
    output logic signed [W-1:0]   o_q
);
    import crs_pkg::*;

    localparam int CW = W + 4;          // coefficient width
    localparam int MW = CW + 17;        // coefficient times Q0.16 power
    localparam int SW = W + 22;         // full cubic sum
    localparam int HW = SW - 16;        // high part of the magnitude
    localparam int PW = HW + 16;        // high part times gain

    logic signed [MW-1:0] w_p1;
    logic signed [MW-1:0] w_p2;
    logic signed [MW-1:0] w_p3;
    logic signed [SW-1:0] w_sum;
    logic [PW-1:0]        w_ph;
    logic [31:0]          w_pl;
    logic [PW:0]          w_scaled;
    logic [PW-14:0]       w_r;
    logic                 w_big;

    logic signed [MW-1:0] r_p1;
    logic signed [MW-1:0] r_p2;
    logic signed [CW-1:0] r_c0;
    logic signed [CW-1:0] r_c3;
    logic signed [MW-1:0] r_p3;
    logic signed [SW-1:0] r_part;
    logic                 r_neg4;
    logic [SW-1:0]        r_mag;
    logic                 r_neg5;
    logic [PW-1:0]        r_ph;
    logic [31:0]          r_pl;
    logic signed [W-1:0]  r_q;

    assign w_p1  = i_c1 * $signed({1'b0, i_t});
    assign w_p2  = i_c2 * $signed({1'b0, i_t2});
    assign w_p3  = r_c3 * $signed({1'b0, i_t3});
    assign w_sum = r_part + SW'(r_p3);
    assign w_ph  = PW'(r_mag[SW-1:16]) * PW'(i_gain);
    assign w_pl  = 32'(r_mag[15:0]) * 32'(i_gain);

    // Gain is Q2.14 and the sum carries 16 fraction bits of t.
    assign w_scaled = (PW+1)'(r_ph) + (PW+1)'(r_pl[31:16]);
    assign w_r      = w_scaled[PW:14];
    assign w_big    = |w_r[PW-14:W-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1   <= w_p1;
            r_p2   <= w_p2;
            r_c0   <= i_c0;
            r_c3   <= i_c3;
            r_p3   <= w_p3;
            r_part <= (SW'(r_c0) <<< 16) + SW'(r_p1) + SW'(r_p2);
            r_neg4 <= w_sum[SW-1];
            r_mag  <= w_sum[SW-1] ? SW'(-w_sum) : SW'(w_sum);
            r_neg5 <= r_neg4;
            r_ph   <= w_ph;
            r_pl   <= w_pl;
            if (w_big) begin
                r_q <= r_neg5 ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end else begin
                r_q <= r_neg5 ? -$signed(w_r[W-1:0]) : $signed(w_r[W-1:0]);
            end
        end
    end

    assign o_q = r_q;

endmodule

### hw/rtl/crs_back.sv
// ============================================================================
// Segment sampler
// Pops segments, steps t across each one and drives three coordinate lanes.
// ============================================================================
module crs_back #(
    parameter int W = crs_pkg::CRS_COORD_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  crs_pkg::t_cfg          i_cfg,
    input  logic [12*W:0]          i_q_data,
    input  crs_pkg::t_q_status     i_q_status,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic signed [W-1:0]    o_qx,
    output logic signed [W-1:0]    o_qy,
    output logic signed [W-1:0]    o_qz,
    output logic                   o_run_end
);
    import crs_pkg::*;

    localparam int CW   = W + 4;
    localparam int NSTG = 6;

    typedef logic [3:0][2:0][W-1:0] t_win;

    t_win                 w_win;
    logic signed [CW-1:0] n_c0 [3];
    logic signed [CW-1:0] n_c1 [3];
    logic signed [CW-1:0] n_c2 [3];
    logic signed [CW-1:0] n_c3 [3];

    logic                 r_busy;
    logic                 r_last;
    logic [15:0]          r_t;
    logic signed [CW-1:0] r_c0 [3];
    logic signed [CW-1:0] r_c1 [3];
    logic signed [CW-1:0] r_c2 [3];
    logic signed [CW-1:0] r_c3 [3];

    logic [NSTG-1:0]      r_v;
    logic [NSTG-1:0]      r_e;
    logic [15:0]          r_s1_t;
    logic [15:0]          r_s1_t2;
    logic signed [CW-1:0] r_s1_c0 [3];
    logic signed [CW-1:0] r_s1_c1 [3];
    logic signed [CW-1:0] r_s1_c2 [3];
    logic signed [CW-1:0] r_s1_c3 [3];
    logic [15:0]          r_s2_t3;

    logic [15:0]          w_step;
    logic [16:0]          w_t_next;
    logic                 w_seg_done;
    logic                 w_en;
    logic                 w_issue;
    logic [31:0]          w_tt;
    logic [31:0]          w_ttt;
    logic signed [W-1:0]  w_q [3];

    assign w_win = i_q_data[12*W-1:0];

    // Cubic coefficients of the popped segment, one set per coordinate.
    always_comb begin
        logic signed [CW-1:0] e0, e1, e2, e3;
        for (int k = 0; k < 3; k++) begin
            e0 = CW'($signed(w_win[0][k]));
            e1 = CW'($signed(w_win[1][k]));
            e2 = CW'($signed(w_win[2][k]));
            e3 = CW'($signed(w_win[3][k]));
            n_c0[k] = e1 <<< 1;
            n_c1[k] = e2 - e0;
            n_c2[k] = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
            n_c3[k] = ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2) + e3 - e0;
        end
    end

    assign w_step     = (i_cfg.t_step < STEP_MIN) ? STEP_MIN : i_cfg.t_step;
    assign w_t_next   = {1'b0, r_t} + {1'b0, w_step};
    assign w_seg_done = w_t_next[16];
    assign w_en       = !(r_v[NSTG-1] && i_out_stall);
    assign w_issue    = r_busy && w_en;
    assign o_pop      = !r_busy && !i_q_status.empty;

    assign w_tt  = 32'(r_t) * 32'(r_t);
    assign w_ttt = 32'(r_s1_t2) * 32'(r_s1_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_v    <= '0;
            r_e    <= '0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (w_issue && w_seg_done) begin
                r_busy <= 1'b0;
            end
            if (w_en) begin
                r_v <= {r_v[NSTG-2:0], w_issue};
                r_e <= {r_e[NSTG-2:0], w_issue && w_seg_done && r_last};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_t    <= 16'd0;
            r_last <= i_q_data[12*W];
            r_c0   <= n_c0;
            r_c1   <= n_c1;
            r_c2   <= n_c2;
            r_c3   <= n_c3;
        end else if (w_issue) begin
            r_t <= w_t_next[15:0];
        end
        if (w_en) begin
            r_s1_t  <= r_t;
            r_s1_t2 <= w_tt[31:16];
            r_s1_c0 <= r_c0;
            r_s1_c1 <= r_c1;
            r_s1_c2 <= r_c2;
            r_s1_c3 <= r_c3;
            r_s2_t3 <= w_ttt[31:16];
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        crs_lane #(
            .W (W)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_gain (i_cfg.gain),
            .i_t    (r_s1_t),
            .i_t2   (r_s1_t2),
            .i_t3   (r_s2_t3),
            .i_c0   (r_s1_c0[g]),
            .i_c1   (r_s1_c1[g]),
            .i_c2   (r_s1_c2[g]),
            .i_c3   (r_s1_c3[g]),
            .o_q    (w_q[g])
        );
    end

    assign o_out_valid = r_v[NSTG-1];
    assign o_run_end   = r_e[NSTG-1];
    assign o_qx        = w_q[0];
    assign o_qy        = w_q[1];
    assign o_qz        = w_q[2];

    a_end_on_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e & ~r_v) == '0)
        else $error("end marker travels without a sample");

    a_load_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_busy && (r_t == 16'd0)))
        else $error("segment load did not restart t");

endmodule

### hw/rtl/catmull_rom_curve_sampler.sv
// ============================================================================
// Catmull-Rom curve sampler
// Streams 3D control points in and Catmull-Rom curve samples out.
// ============================================================================
// Control points enter one beat at a time; the first and last point of every
// curve are doubled, and every point that completes a four-point window
// starts one segment, sampled at t = 0, t_step, 2*t_step, ... while t < 1 and
// scaled by gain (Q2.14), with results saturated to the coordinate range. A
// point marked final also emits the closing segment, and run_end flags the
// last sample caused by each input beat. The front end takes one input beat
// per cycle whenever the two-entry segment queue has room; a final point that
// completes two segments holds the input until its closing segment is queued.
// After the last sample of a segment is issued the sampler loads the next one
// from the queue, then gives one sample per cycle while the output is not
// stalled, so a segment yields ceil(65536 / max(t_step, 2048)) samples; one
// input beat starts at most two segments. The sustained rate is set by this
// sample loop. An output stall while a sample waits at the output freezes the
// whole sample pipeline, while the front end keeps filling the queue.
// Configuration registers (index 0 is t_step, index 1 is gain, others are
// ignored) are always ready and must be written only while the block is idle.
module catmull_rom_curve_sampler #(
    parameter int COORD_WIDTH = crs_pkg::CRS_COORD_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Control point input channel.
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [COORD_WIDTH-1:0]   i_px,
    input  logic signed [COORD_WIDTH-1:0]   i_py,
    input  logic signed [COORD_WIDTH-1:0]   i_pz,
    input  logic                            i_final_point,
    // Sample output channel.
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [COORD_WIDTH-1:0]   o_qx,
    output logic signed [COORD_WIDTH-1:0]   o_qy,
    output logic signed [COORD_WIDTH-1:0]   o_qz,
    output logic                            o_run_end,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [crs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [15:0]                     i_cfg_data
);
    import crs_pkg::*;

    // A queued segment is four points of three coordinates plus its end flag.
    localparam int JW = 12 * COORD_WIDTH + 1;

    logic [15:0] r_t_step;
    logic [15:0] r_gain;
    t_cfg        w_cfg;
    t_q_status   w_q_status;
    logic        w_push;
    logic [JW-1:0] w_push_data;
    logic        w_pop;
    logic [JW-1:0] w_pop_data;

    // The register file never stalls a write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_step <= T_STEP_RESET;
            r_gain   <= GAIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_T_STEP: begin
                    r_t_step <= i_cfg_data;
                end
                REG_GAIN: begin
                    r_gain <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.t_step = r_t_step;
    assign w_cfg.gain   = r_gain;

    // The front end owns the point window and turns points into segments.
    crs_front #(
        .W (COORD_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_px          (i_px),
        .i_py          (i_py),
        .i_pz          (i_pz),
        .i_final_point (i_final_point),
        .o_push        (w_push),
        .o_push_data   (w_push_data),
        .i_q_status    (w_q_status)
    );

    crs_queue #(
        .WIDTH (JW),
        .DEPTH (CRS_QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_status    (w_q_status)
    );

    // The sampler walks t over each queued segment, one sample per cycle while the output is not stalled.
    crs_back #(
        .W (COORD_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_q_data    (w_pop_data),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_qx        (o_qx),
        .o_qy        (o_qy),
        .o_qz        (o_qz),
        .o_run_end   (o_run_end)
    );

endmodule
